// ===== sv/adaptive_threshold_beat_detector_assert.svh =====
// assertion macros for the beat detector
// used by the top level only, no other dependencies
`ifndef ADAPTIVE_THRESHOLD_BEAT_DETECTOR_ASSERT_SVH
`define ADAPTIVE_THRESHOLD_BEAT_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ATBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("beat detector check failed");

// next-cycle implication, disabled while in reset
`define ATBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("beat detector check failed");

`endif

// ===== sv/atbd_pkg.sv =====
// shared types and constants for the beat detector
// no dependencies
`default_nettype none

package atbd_pkg;

	localparam int SAMPLE_W = 18;
	localparam int FRAC_W   = 14;
	localparam int LEVEL_W  = SAMPLE_W + FRAC_W;
	localparam int TIME_W   = 32;
	localparam int RATE_W   = 16;
	localparam int BPM_W    = 8;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 18;
	localparam int MULB_W   = RATE_W + 1;
	localparam int PROD_W   = LEVEL_W + 1;
	localparam int DIV_W    = 16;
	localparam int DIVCNT_W = 4;

	localparam logic [MULB_W-1:0] Q16_ONE = MULB_W'(17'h10000);
	localparam logic [DIV_W-1:0]  BPM_NUM = DIV_W'(60000);
	localparam logic [BPM_W-1:0]  BPM_MAX = BPM_W'(255);
	localparam logic [DIVCNT_W-1:0] DIV_LAST = DIVCNT_W'(DIV_W - 1);

	// configuration register indexes
	localparam logic [CFG_AW-1:0] REG_RATIO      = 3'd0;
	localparam logic [CFG_AW-1:0] REG_DECAY      = 3'd1;
	localparam logic [CFG_AW-1:0] REG_SMOOTH     = 3'd2;
	localparam logic [CFG_AW-1:0] REG_MIN_SPREAD = 3'd3;
	localparam logic [CFG_AW-1:0] REG_REFRACTORY = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M1,
		S_TGT,
		S_M3,
		S_THR,
		S_TEST,
		S_DIV,
		S_M4,
		S_M5,
		S_DEC,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_SPREAD,
		MUL_THR,
		MUL_TGT,
		MUL_MAXD,
		MUL_MIND
	} mul_op_t;

	typedef struct packed {
		logic    load;
		mul_op_t mul_op;
		logic    tgt_ld;
		logic    acc_ld;
		logic    thr_ld;
		logic    last_ld;
		logic    seen_set;
		logic    div_start;
		logic    div_step;
		logic    env_max;
		logic    env_min;
		logic    res_ld;
		logic    res_rate;
	} dp_cmd_t;

	typedef struct packed {
		logic beat;
		logic seen;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/atbd_dp.sv =====
// datapath: envelopes, threshold, shared multiplier, serial divider, result word
// depends on atbd_pkg
`default_nettype none

module atbd_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire atbd_pkg::dp_cmd_t               cmd,
	output atbd_pkg::dp_status_t                 status,
	input  wire logic [atbd_pkg::SAMPLE_W-1:0]   in_sample,
	input  wire logic [atbd_pkg::TIME_W-1:0]     in_now,
	input  wire logic                            cfg_we,
	input  wire logic [atbd_pkg::CFG_AW-1:0]     cfg_addr,
	input  wire logic [atbd_pkg::CFG_DW-1:0]     cfg_wdata,
	output logic                                 res_rate_valid,
	output logic [atbd_pkg::BPM_W-1:0]           res_bpm
);
	import atbd_pkg::*;

	logic [RATE_W-1:0]   ratio_q, decay_q, smooth_q, refr_q;
	logic [SAMPLE_W-1:0] min_spread_q;

	logic [SAMPLE_W-1:0] sample_q, prev_q;
	logic [TIME_W-1:0]   now_q, last_q, dt_q;
	logic [LEVEL_W-1:0]  cur_q, max_q, min_q, thr_q, tgt_q;
	logic                seen_q;
	logic [PROD_W-1:0]   prod_q, acc_q;

	logic [DIV_W:0]      rem_q;
	logic [DIV_W-1:0]    num_q, quo_q;

	logic [LEVEL_W-1:0]  cur_in, spread, mul_a;
	logic [MULB_W-1:0]   mul_b;
	logic [LEVEL_W+MULB_W-1:0] mul_full;
	logic [PROD_W:0]     thr_sum, thr_lo;
	logic [LEVEL_W-1:0]  thr_new;
	logic [DIV_W:0]      rem_sh;
	logic                div_ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q      <= RATE_W'(45875);
			decay_q      <= RATE_W'(1311);
			smooth_q     <= RATE_W'(3277);
			min_spread_q <= SAMPLE_W'(50);
			refr_q       <= RATE_W'(300);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RATIO:      ratio_q      <= cfg_wdata[RATE_W-1:0];
				REG_DECAY:      decay_q      <= cfg_wdata[RATE_W-1:0];
				REG_SMOOTH:     smooth_q     <= cfg_wdata[RATE_W-1:0];
				REG_MIN_SPREAD: min_spread_q <= cfg_wdata[SAMPLE_W-1:0];
				REG_REFRACTORY: refr_q       <= cfg_wdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cur_in = {in_sample, {FRAC_W{1'b0}}};
	assign spread = (max_q >= min_q) ? (max_q - min_q) : '0;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_SPREAD: begin
				mul_a = spread;
				mul_b = {1'b0, ratio_q};
			end
			MUL_THR: begin
				mul_a = thr_q;
				mul_b = Q16_ONE - {1'b0, smooth_q};
			end
			MUL_TGT: begin
				mul_a = tgt_q;
				mul_b = {1'b0, smooth_q};
			end
			MUL_MAXD: begin
				mul_a = (max_q > cur_q) ? (max_q - cur_q) : '0;
				mul_b = {1'b0, decay_q};
			end
			MUL_MIND: begin
				mul_a = (cur_q > min_q) ? (cur_q - min_q) : '0;
				mul_b = {1'b0, decay_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// 32x17 product, truncated q1.16 scaling
	assign mul_full = {{MULB_W{1'b0}}, mul_a} * {{LEVEL_W{1'b0}}, mul_b};

	always_ff @(posedge clk) begin
		prod_q <= mul_full[RATE_W +: PROD_W];
	end

	// smoothed threshold, clamped to the envelopes
	assign thr_sum = {1'b0, acc_q} + {1'b0, prod_q};
	assign thr_lo  = (thr_sum < {2'b00, min_q}) ? {2'b00, min_q} : thr_sum;
	assign thr_new = (thr_lo > {2'b00, max_q}) ? max_q : thr_lo[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= '0;
			min_q  <= '0;
			thr_q  <= '0;
			prev_q <= '0;
			last_q <= '0;
			seen_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (cur_in > max_q) max_q <= cur_in;
				if (cur_in < min_q) min_q <= cur_in;
			end else if (cmd.env_max) begin
				max_q <= max_q - prod_q[LEVEL_W-1:0];
			end else if (cmd.env_min) begin
				min_q <= min_q + prod_q[LEVEL_W-1:0];
			end
			if (cmd.env_min) prev_q <= sample_q;
			if (cmd.thr_ld) thr_q <= thr_new;
			if (cmd.last_ld) last_q <= now_q;
			if (cmd.seen_set) seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_sample;
			now_q    <= in_now;
			cur_q    <= cur_in;
		end
		if (cmd.tgt_ld) tgt_q <= min_q + prod_q[LEVEL_W-1:0];
		if (cmd.acc_ld) acc_q <= prod_q;
		if (cmd.thr_ld) dt_q <= now_q - last_q;
	end

	assign status.seen = seen_q;
	assign status.beat = (cur_q >= thr_q)
		&& ({prev_q, {FRAC_W{1'b0}}} < thr_q)
		&& (spread > {min_spread_q, {FRAC_W{1'b0}}})
		&& (dt_q > {{(TIME_W-RATE_W){1'b0}}, refr_q});

	// restoring divider, one quotient bit a cycle
	assign rem_sh = {rem_q[DIV_W-1:0], num_q[DIV_W-1]};
	assign div_ge = {{(TIME_W-DIV_W-1){1'b0}}, rem_sh} >= dt_q;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			num_q <= BPM_NUM;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? (rem_sh - dt_q[DIV_W:0]) : rem_sh;
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], div_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			res_rate_valid <= cmd.res_rate;
			if (!cmd.res_rate)
				res_bpm <= '0;
			else if (quo_q > {{(DIV_W-BPM_W){1'b0}}, BPM_MAX})
				res_bpm <= BPM_MAX;
			else
				res_bpm <= quo_q[BPM_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== sv/atbd_ctrl.sv =====
// controller: sequences one sample through the datapath, owns the handshakes
// depends on atbd_pkg
`default_nettype none

module atbd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire atbd_pkg::dp_status_t status,
	output atbd_pkg::dp_cmd_t         cmd
);
	import atbd_pkg::*;

	state_t state_q, state_d;
	logic [DIVCNT_W-1:0] cnt_q;
	logic rate_q, out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_M1;
			S_M1:   state_d = S_TGT;
			S_TGT:  state_d = S_M3;
			S_M3:   state_d = S_THR;
			S_THR:  state_d = S_TEST;
			S_TEST: state_d = (status.beat && status.seen) ? S_DIV : S_M4;
			S_DIV:  if (cnt_q == DIV_LAST) state_d = S_OUT;
			S_M4:   state_d = S_M5;
			S_M5:   state_d = S_DEC;
			S_DEC:  state_d = S_OUT;
			S_OUT:  if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_op = MUL_SPREAD;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_M1: cmd.mul_op = MUL_SPREAD;
			S_TGT: begin
				cmd.tgt_ld = 1'b1;
				cmd.mul_op = MUL_THR;
			end
			S_M3: begin
				cmd.acc_ld = 1'b1;
				cmd.mul_op = MUL_TGT;
			end
			S_THR: cmd.thr_ld = 1'b1;
			S_TEST: begin
				cmd.last_ld   = status.beat;
				cmd.seen_set  = status.beat && !status.seen;
				cmd.div_start = status.beat && status.seen;
			end
			S_DIV: cmd.div_step = 1'b1;
			S_M4: cmd.mul_op = MUL_MAXD;
			S_M5: begin
				cmd.env_max = 1'b1;
				cmd.mul_op  = MUL_MIND;
			end
			S_DEC: cmd.env_min = 1'b1;
			S_OUT: begin
				cmd.res_ld   = slot_free;
				cmd.res_rate = rate_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rate_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_TEST) begin
				rate_q <= status.beat && status.seen;
				cnt_q  <= '0;
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.res_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/adaptive_threshold_beat_detector.sv =====
// adaptive threshold beat detector, top level
// input words carry one optical sample and its millisecond timestamp; each input
// word yields exactly one output word: a rate flag in tuser and bpm in tdata
// the sample is taken on s_axis when tvalid and tready are both high; tready is
// high only while the controller waits for a new sample
// a sample passes through the shared multiplier steps, the threshold test and, when a beat
// rate is reported, the serial bpm divider before its word is loaded into the output
// register; one sample is processed at a time, so a new sample is only taken once the
// previous one has reached the output register
// the output word sits in a register; a new sample is taken while it waits,
// and the controller holds its next result until the receiver takes the old one
// reset: envelopes, threshold, previous sample and last beat time clear to zero,
// no beat is recorded yet, and the configuration registers return to defaults
// configuration: cfg_we writes cfg_wdata to register cfg_addr in the same edge;
// only write while no sample is in flight
`default_nettype none

module adaptive_threshold_beat_detector (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // [17:0] sample, [49:18] now_ms, rest zero
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] bpm
	output logic             m_axis_tuser,  // [0] rate_valid
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [17:0] cfg_wdata
);
	import atbd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic [SAMPLE_W-1:0] in_sample;
	logic [TIME_W-1:0]   in_now;

	// unpack the input word
	assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
	assign in_now    = s_axis_tdata[SAMPLE_W +: TIME_W];

	// sequencer: handshakes and step commands
	atbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// envelopes, threshold, multiplier, divider and result register
	atbd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_sample      (in_sample),
		.in_now         (in_now),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.res_rate_valid (m_axis_tuser),
		.res_bpm        (m_axis_tdata)
	);

`include "adaptive_threshold_beat_detector_assert.svh"

	// bpm must read zero whenever no rate is reported
	`ATBD_ASSERT_NOW(a_bpm_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 8'd0)
	// one sample at a time: busy right after an accept
	`ATBD_ASSERT_NEXT(a_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// a sample is never taken in the same cycle a result is loaded
	`ATBD_ASSERT_NOW(a_no_overlap, clk, arst_n, cmd.res_ld, !cmd.load)

endmodule

`default_nettype wire

// ===== tb/tb_adaptive_threshold_beat_detector.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the adaptive threshold beat detector
// predicts every output word from its own copy of the envelope state
// needs atbd_pkg and the detector top level

module tb_adaptive_threshold_beat_detector;

	import atbd_pkg::*;

	localparam logic [63:0] LEVEL_MASK = (64'd1 << LEVEL_W) - 64'd1;
	localparam int          SAMPLE_TOP = (1 << SAMPLE_W) - 1;

	// one predicted output word
	typedef struct packed {
		logic             rate_valid;
		logic [BPM_W-1:0] bpm;
	} rate_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [55:0]       s_axis_tdata = '0;   // [17:0] sample, [49:18] now_ms, rest zero
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // [7:0] bpm
	logic              m_axis_tuser;        // [0] rate_valid
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_addr = '0;
	logic [17:0]       cfg_wdata = '0;

	// predicted words waiting for the block, oldest first
	rate_word_t expected_rates[$];
	int         rate_errors = 0;

	// idle probabilities in percent, changed per phase
	int send_idle_pct = 0;
	int stall_pct = 0;

	// running time stamp of the synthetic pulse trains
	logic [TIME_W-1:0] stamp_ms = 32'd0;

	// predictor copy of the configuration, starting at the reset values
	logic [RATE_W-1:0]   cfg_ratio      = 16'd45875;
	logic [RATE_W-1:0]   cfg_decay      = 16'd1311;
	logic [RATE_W-1:0]   cfg_smooth     = 16'd3277;
	logic [SAMPLE_W-1:0] cfg_min_spread = 18'd50;
	logic [RATE_W-1:0]   cfg_refractory = 16'd300;

	// predictor copy of the detector state; levels kept wide, masked to LEVEL_W
	logic [63:0]         env_max = '0;
	logic [63:0]         env_min = '0;
	logic [63:0]         thr_level = '0;
	logic [SAMPLE_W-1:0] prev_sample = '0;
	logic [TIME_W-1:0]   last_beat_ms = '0;
	logic                beat_held = 1'b0;

	adaptive_threshold_beat_detector dut (.*);

	always #4 clk = ~clk;

	// receiver side: tready redrawn at every falling edge
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// floor(x * r / 65536), each product truncated on its own
	function automatic logic [63:0] scale_q16(input logic [63:0] x, input logic [16:0] r);
		return (x >> 16) * r + (((x & 64'hFFFF) * r) >> 16);
	endfunction

	// advance the predicted state by one sample and queue the expected word
	task automatic predict_rate(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] ms);
		logic [63:0]       cur;
		logic [63:0]       spread;
		logic [63:0]       target;
		logic [63:0]       thr;
		logic [63:0]       prev_lvl;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] quot;
		rate_word_t        word;
		cur = 64'(smp) << FRAC_W;
		if (cur > env_max) env_max = cur;
		if (cur < env_min) env_min = cur;
		// inverted envelopes count as no spread
		spread = (env_max >= env_min) ? env_max - env_min : 64'd0;
		target = (env_min + scale_q16(spread, {1'b0, cfg_ratio})) & LEVEL_MASK;
		thr = scale_q16(thr_level, Q16_ONE - {1'b0, cfg_smooth})
			+ scale_q16(target, {1'b0, cfg_smooth});
		if (thr < env_min) thr = env_min;
		if (thr > env_max) thr = env_max;
		thr_level = thr & LEVEL_MASK;
		prev_lvl = 64'(prev_sample) << FRAC_W;
		interval = ms - last_beat_ms;   // wraps modulo 2^32
		word = '0;
		if (cur >= thr_level && prev_lvl < thr_level
			&& spread > (64'(cfg_min_spread) << FRAC_W)
			&& interval > TIME_W'(cfg_refractory)) begin
			last_beat_ms = ms;
			if (beat_held) begin
				// interval is at least one here, saturate fast rates
				quot = 32'd60000 / interval;
				word.rate_valid = 1'b1;
				word.bpm = (quot > 32'd255) ? BPM_MAX : quot[BPM_W-1:0];
			end else begin
				// first beat only records its time
				beat_held = 1'b1;
			end
		end
		// a reported beat skips the decay and keeps the old previous sample
		if (!word.rate_valid) begin
			if (env_max > cur) env_max = env_max - scale_q16(env_max - cur, {1'b0, cfg_decay});
			if (cur > env_min) env_min = env_min + scale_q16(cur - env_min, {1'b0, cfg_decay});
			env_max &= LEVEL_MASK;
			env_min &= LEVEL_MASK;
			prev_sample = smp;
		end
		expected_rates.push_back(word);
	endtask

	// present one sample word, wait for the handshake, predict on acceptance
	// returns at the following falling edge with tvalid still high
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] ms);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, ms, smp};
		do @(posedge clk); while (!s_axis_tready);
		predict_rate(smp, ms);
		@(negedge clk);
	endtask

	// stop sending and wait until every predicted word has come back
	task automatic wait_rates_done();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (expected_rates.size() != 0);
	endtask

	// write all five registers; only called with the block idle
	task automatic apply_settings(input logic [RATE_W-1:0] ratio, input logic [RATE_W-1:0] decay,
		input logic [RATE_W-1:0] smooth, input logic [SAMPLE_W-1:0] spread,
		input logic [RATE_W-1:0] refractory);
		logic [CFG_AW-1:0] idx [5] = '{REG_RATIO, REG_DECAY, REG_SMOOTH, REG_MIN_SPREAD,
			REG_REFRACTORY};
		logic [CFG_DW-1:0] val [5];
		val = '{CFG_DW'(ratio), CFG_DW'(decay), CFG_DW'(smooth), spread, CFG_DW'(refractory)};
		wait_rates_done();
		repeat (2) @(negedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_wdata <= val[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cfg_ratio      = ratio;
		cfg_decay      = decay;
		cfg_smooth     = smooth;
		cfg_min_spread = spread;
		cfg_refractory = refractory;
	endtask

	// none, sender idle, receiver stalling, both
	task automatic select_idling(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 71; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 71; end
			default: begin send_idle_pct = 31; stall_pct = 31; end
		endcase
	endtask

	// synthetic pulse trains with random shape, level and rate, mixed with noise words
	task automatic send_pulse_trains(input int n_items);
		int sent;
		int period;
		int duty;
		int shape;
		int base;
		int amp;
		int noise;
		int step_ms;
		int len;
		int wave;
		int level;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 15) begin
				// noise word, sometimes with a time stamp anywhere on the wrap
				if ($urandom_range(1) == 1) stamp_ms = $urandom;
				else stamp_ms = stamp_ms + TIME_W'($urandom_range(1, 400));
				send_sample(SAMPLE_W'($urandom), stamp_ms);
				sent++;
			end else begin
				period  = $urandom_range(3, 80);
				duty    = $urandom_range(1, period - 1);
				shape   = $urandom_range(2);
				base    = $urandom_range(0, 200000);
				amp     = ($urandom_range(4) == 0) ? $urandom_range(0, SAMPLE_TOP)
					: $urandom_range(40, 60000);
				noise   = $urandom_range(0, amp / 8);
				step_ms = $urandom_range(1, 25);
				// short trains break the sequence early
				len     = ($urandom_range(9) == 0) ? $urandom_range(1, period)
					: $urandom_range(2, 8) * period;
				for (int i = 0; i < len && sent < n_items; i++) begin
					case (shape)
						0: wave = ((i % period) < duty) ? amp : 0;
						1: wave = amp / period * (i % period);
						default: wave = amp / period * (period - (i % period));
					endcase
					level = base + wave + $urandom_range(0, noise) - noise / 2;
					if (level < 0) level = 0;
					if (level > SAMPLE_TOP) level = SAMPLE_TOP;
					stamp_ms = stamp_ms + TIME_W'(step_ms)
						+ (($urandom_range(19) == 0) ? TIME_W'($urandom_range(0, 50)) : 32'd0);
					send_sample(SAMPLE_W'(level), stamp_ms);
					sent++;
					// now and then hold off until the block has drained
					if ($urandom_range(199) == 0) wait_rates_done();
				end
			end
		end
	endtask

	// reset settings: zero fields, first beat, reported beat, refractory edge,
	// huge interval giving a zero rate
	task automatic test_first_beat_and_refractory();
		logic [SAMPLE_W-1:0] smp [10] = '{18'd0, 18'h3FFFF, 18'd0, 18'h3FFFF, 18'd0,
			18'h3FFFF, 18'd0, 18'h3FFFF, 18'd0, 18'h3FFFF};
		logic [TIME_W-1:0] ms [10] = '{32'd0, 32'd500, 32'd600, 32'd1500, 32'd1600,
			32'd1800, 32'd1900, 32'd2101, 32'd2200, 32'hFFFF_FFFF};
		select_idling(0);
		for (int i = 0; i < 10; i++) send_sample(smp[i], ms[i]);
		wait_rates_done();
	endtask

	// no refractory time: one and two ms intervals saturate the rate,
	// back to back high samples hit the path that keeps the old previous sample
	task automatic test_rate_saturation();
		logic [SAMPLE_W-1:0] smp [8] = '{18'd0, 18'h3FFFF, 18'd0, 18'h3FFFF, 18'd0,
			18'h3FFFF, 18'h3FFFF, 18'h3FFFF};
		apply_settings(16'd45875, 16'd1311, 16'd3277, 18'd50, 16'd0);
		for (int i = 0; i < 8; i++) send_sample(smp[i], 32'd3000 + TIME_W'(i));
		wait_rates_done();
	endtask

	// beat interval measured across the time stamp wrap
	task automatic test_timestamp_wrap();
		logic [SAMPLE_W-1:0] smp [6] = '{18'd0, 18'h3FFFF, 18'd0, 18'h3FFFF, 18'd0, 18'h3FFFF};
		logic [TIME_W-1:0] ms [6] = '{32'hFFFF_FE00, 32'hFFFF_FF00, 32'hFFFF_FF80,
			32'h0000_0100, 32'h0000_0180, 32'h0000_03FF};
		apply_settings(16'd45875, 16'd1311, 16'd3277, 18'd50, 16'd300);
		for (int i = 0; i < 6; i++) send_sample(smp[i], ms[i]);
		wait_rates_done();
	endtask

	// all registers at their lowest, then at their highest
	task automatic test_register_extremes();
		apply_settings(16'd0, 16'd0, 16'd0, 18'd0, 16'd0);
		select_idling(1);
		send_pulse_trains(220);
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 16'hFFFF);
		select_idling(2);
		send_pulse_trains(220);
	endtask

	// reset values once more, then random settings, cycling the idle modes
	task automatic test_random_settings();
		apply_settings(16'd45875, 16'd1311, 16'd3277, 18'd50, 16'd300);
		select_idling(0);
		send_pulse_trains(205);
		for (int phase = 1; phase < 7; phase++) begin
			apply_settings(RATE_W'($urandom),
				($urandom_range(1) == 1) ? RATE_W'($urandom_range(0, 4000)) : RATE_W'($urandom),
				RATE_W'($urandom),
				($urandom_range(1) == 1) ? SAMPLE_W'($urandom_range(0, 1000)) : SAMPLE_W'($urandom),
				($urandom_range(1) == 1) ? RATE_W'($urandom_range(0, 1000)) : RATE_W'($urandom));
			select_idling(phase + 2);
			send_pulse_trains(205);
		end
	endtask

	// every accepted output word against the oldest prediction
	always @(posedge clk) begin : check_rates
		rate_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rates.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual rate_valid=%0d bpm=%0d",
					$time, m_axis_tuser, m_axis_tdata);
				rate_errors++;
			end else begin
				want = expected_rates.pop_front();
				if (m_axis_tuser !== want.rate_valid) begin
					$display("%0t: rate_valid mismatch, expected %0d, actual %0d",
						$time, want.rate_valid, m_axis_tuser);
					rate_errors++;
				end
				if (m_axis_tdata !== want.bpm) begin
					$display("%0t: bpm mismatch, expected %0d, actual %0d",
						$time, want.bpm, m_axis_tdata);
					rate_errors++;
				end
			end
		end
	end

	// main sequence
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_first_beat_and_refractory();
		test_rate_saturation();
		test_timestamp_wrap();
		test_register_extremes();
		test_random_settings();
		wait_rates_done();
		// let any stray word show up before the verdict
		repeat (40) @(negedge clk);
		if (rate_errors == 0 && expected_rates.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
